### rtl/modbus_rtu_frame_fsm_defines.svh
// Assertion macros for the Modbus RTU framing block.
// Used by the modules that carry checks; no other dependencies.
`ifndef MODBUS_RTU_FRAME_FSM_DEFINES_SVH
`define MODBUS_RTU_FRAME_FSM_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle
`define MRTU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the following cycle
`define MRTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MRTU_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define MRTU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/mrtu_pkg.sv
// Shared types and constants of the Modbus RTU framing block.
// No dependencies; mrtu_ctrl and the top refer to it by scoped names, the testbench imports it.
package mrtu_pkg;

    // Link states of the framing machine
    typedef enum logic [2:0] {
        ST_INIT       = 3'd0,
        ST_IDLE       = 3'd1,
        ST_EMIT       = 3'd2,
        ST_RECEIVE    = 3'd3,
        ST_WAIT       = 3'd4,
        ST_PROCESS    = 3'd5,
        ST_WAIT_TX    = 3'd6,
        ST_TX_TIMEOUT = 3'd7
    } link_state_t;

    // Status codes returned with every word
    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_AGAIN    = 3'd1,
        STS_BUSY     = 3'd2,
        STS_FAULT    = 3'd3,
        STS_INVALID  = 3'd4,
        STS_NOBUF    = 3'd5,
        STS_TIMEDOUT = 3'd6,
        STS_WRERR    = 3'd7
    } status_t;

    // Command codes carried in the cmd field
    localparam logic [2:0] CMD_RX      = 3'd0;
    localparam logic [2:0] CMD_EXPIRY  = 3'd1;
    localparam logic [2:0] CMD_RELEASE = 3'd2;
    localparam logic [2:0] CMD_WRITE   = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_STATION   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_SHORT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_LONG  = 2'd2;

    localparam logic [7:0]  STATION_RESET   = 8'd1;
    localparam logic [15:0] GAP_SHORT_RESET = 16'd1719;
    localparam logic [15:0] GAP_LONG_RESET  = 16'd4010;

    // Configuration as seen by the control logic
    typedef struct packed {
        logic [7:0]  station_address;
        logic [15:0] gap_short_us;
        logic [15:0] gap_long_us;
    } cfg_t;

    // One input word
    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  rx_data;
        logic [7:0]  read_index;
        logic [15:0] caller_capacity;
        logic [15:0] tx_length;
        logic [7:0]  tx_tag;
        logic [15:0] tx_taken;
        logic        tx_error;
    } in_item_t;

endpackage

### rtl/mrtu_in_if.sv
// Input channel of the framing block: valid/ready handshake with the command word.
// Depends on nothing.
interface mrtu_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  rx_data;
    logic [7:0]  read_index;
    logic [15:0] caller_capacity;
    logic [15:0] tx_length;
    logic [7:0]  tx_tag;
    logic [15:0] tx_taken;
    logic        tx_error;

    modport source (
        output valid, cmd, rx_data, read_index, caller_capacity,
               tx_length, tx_tag, tx_taken, tx_error,
        input  ready
    );
    modport sink (
        input  valid, cmd, rx_data, read_index, caller_capacity,
               tx_length, tx_tag, tx_taken, tx_error,
        output ready
    );
endinterface

### rtl/mrtu_out_if.sv
// Result channel of the framing block: valid/ready handshake with the result word.
// CNT_W sets the width of the byte count fields; depends on nothing.
interface mrtu_out_if #(
    parameter int CNT_W = 9
);
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic             timer_start;
    logic [15:0]      timer_load_us;
    logic             frame_ready;
    logic [CNT_W-1:0] frame_length;
    logic [7:0]       read_data;
    logic [CNT_W-1:0] tx_resume_offset;

    modport source (
        output valid, status, timer_start, timer_load_us, frame_ready,
               frame_length, read_data, tx_resume_offset,
        input  ready
    );
    modport sink (
        input  valid, status, timer_start, timer_load_us, frame_ready,
               frame_length, read_data, tx_resume_offset,
        output ready
    );
endinterface

### rtl/mrtu_store.sv
// Frame byte store: one write port and one registered read port.
// Depends on nothing; contents are undefined until written.
module mrtu_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    // Write a received byte
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read byte
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/mrtu_ctrl.sv
// Framing state machine: link state, byte count, transmit tracking and result registers.
// Depends on mrtu_pkg and the assertion macros in modbus_rtu_frame_fsm_defines.svh.
`include "modbus_rtu_frame_fsm_defines.svh"
module mrtu_ctrl #(
    parameter int FRAME_BYTES = 256,
    parameter int AW          = 8,
    parameter int CNT_W       = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  mrtu_pkg::in_item_t item,
    input  mrtu_pkg::cfg_t     cfg,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [7:0]         wr_data,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    output logic [2:0]         status_reg,
    output logic               tstart_reg,
    output logic [15:0]        tload_reg,
    output logic               ready_reg,
    output logic [CNT_W-1:0]   flen_reg,
    output logic [CNT_W-1:0]   resume_reg,
    output logic               read_sel_reg
);

    localparam logic [15:0]      FRAME_W16 = 16'(FRAME_BYTES);
    localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BYTES);

    // Fold a byte index into the store depth by restoring subtraction
    function automatic logic [AW-1:0] wrap_index(input logic [7:0] idx);
        logic [15:0] v;
        v = {8'd0, idx};
        for (int k = 5; k >= 0; k--)
        begin
            if (v >= 16'(FRAME_BYTES << k))
            begin
                v = v - 16'(FRAME_BYTES << k);
            end
        end
        return AW'(v);
    endfunction

    mrtu_pkg::link_state_t st_reg, st_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       tag_reg, tag_next;
    logic [15:0]      plen_reg, plen_next;
    logic [7:0]       first_byte_reg;

    mrtu_pkg::status_t status;
    logic              tstart;
    logic [15:0]       tload;
    logic              rdy;
    logic [CNT_W-1:0]  flen;

    logic [15:0] cnt16;
    logic [15:0] remaining;
    logic [15:0] gap_diff;
    logic        tx_oversize;
    logic        store_full;
    logic        addr_hit;

    // Shared decode terms
    always_comb
    begin
        cnt16       = 16'(cnt_reg);
        remaining   = item.tx_length - cnt16;
        gap_diff    = (cfg.gap_long_us >= cfg.gap_short_us)
                    ? (cfg.gap_long_us - cfg.gap_short_us) : 16'd0;
        tx_oversize = item.tx_length > FRAME_W16;
        store_full  = cnt_reg >= FRAME_CNT;
        addr_hit    = (first_byte_reg == 8'd0) || (first_byte_reg == cfg.station_address);
    end

    // Next state, counters and store write
    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        tag_next  = tag_reg;
        plen_next = plen_reg;
        wr_en     = 1'b0;
        wr_addr   = cnt_reg[AW-1:0];
        wr_data   = item.rx_data;
        unique case (item.cmd)
            mrtu_pkg::CMD_RX:
            begin
                if (st_reg == mrtu_pkg::ST_IDLE)
                begin
                    wr_en    = fire;
                    wr_addr  = '0;
                    cnt_next = CNT_W'(1);
                    st_next  = mrtu_pkg::ST_RECEIVE;
                end
                else if (st_reg == mrtu_pkg::ST_RECEIVE && !store_full)
                begin
                    wr_en    = fire;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            mrtu_pkg::CMD_EXPIRY:
            begin
                unique case (st_reg)
                    mrtu_pkg::ST_INIT:
                    begin
                        st_next  = mrtu_pkg::ST_IDLE;
                        cnt_next = '0;
                    end
                    mrtu_pkg::ST_EMIT:    st_next = mrtu_pkg::ST_TX_TIMEOUT;
                    mrtu_pkg::ST_RECEIVE: st_next = mrtu_pkg::ST_WAIT;
                    mrtu_pkg::ST_WAIT:
                        st_next = addr_hit ? mrtu_pkg::ST_PROCESS : mrtu_pkg::ST_IDLE;
                    mrtu_pkg::ST_WAIT_TX: st_next = mrtu_pkg::ST_IDLE;
                    default:              st_next = st_reg;
                endcase
            end
            mrtu_pkg::CMD_RELEASE:
            begin
                if (st_reg == mrtu_pkg::ST_PROCESS && cnt16 < item.caller_capacity)
                begin
                    st_next = mrtu_pkg::ST_IDLE;
                end
            end
            mrtu_pkg::CMD_WRITE:
            begin
                if (!tx_oversize)
                begin
                    unique case (st_reg)
                        mrtu_pkg::ST_IDLE:
                        begin
                            priority if (item.tx_length == 16'd0 || item.tx_error)
                            begin
                                st_next = st_reg;
                            end
                            else if (item.tx_taken < item.tx_length)
                            begin
                                cnt_next  = CNT_W'(item.tx_taken);
                                st_next   = mrtu_pkg::ST_EMIT;
                                tag_next  = item.tx_tag;
                                plen_next = item.tx_length;
                            end
                            else
                            begin
                                st_next = mrtu_pkg::ST_WAIT_TX;
                            end
                        end
                        mrtu_pkg::ST_EMIT:
                        begin
                            priority if (cnt16 >= item.tx_length || item.tx_tag != tag_reg
                                         || item.tx_length != plen_reg)
                            begin
                                st_next = st_reg;
                            end
                            else if (item.tx_error || item.tx_taken == remaining)
                            begin
                                st_next = mrtu_pkg::ST_WAIT_TX;
                            end
                            else if (item.tx_taken < remaining)
                            begin
                                cnt_next = CNT_W'(cnt16 + item.tx_taken);
                            end
                            else
                            begin
                                st_next = st_reg;
                            end
                        end
                        mrtu_pkg::ST_TX_TIMEOUT:
                        begin
                            if (item.tx_tag == tag_reg)
                            begin
                                st_next = mrtu_pkg::ST_WAIT_TX;
                            end
                        end
                        default: st_next = st_reg;
                    endcase
                end
            end
            default: st_next = st_reg;
        endcase
    end

    // Result word: status, timer restart, frame ready and length
    always_comb
    begin
        status = mrtu_pkg::STS_OK;
        tstart = 1'b0;
        tload  = 16'd0;
        rdy    = 1'b0;
        flen   = '0;
        unique case (item.cmd)
            mrtu_pkg::CMD_RX:
            begin
                unique case (st_reg)
                    mrtu_pkg::ST_INIT:
                    begin
                        tstart = 1'b1;
                        tload  = cfg.gap_long_us;
                        status = mrtu_pkg::STS_AGAIN;
                    end
                    mrtu_pkg::ST_IDLE:
                    begin
                        tstart = 1'b1;
                        tload  = cfg.gap_short_us;
                    end
                    mrtu_pkg::ST_RECEIVE:
                    begin
                        if (store_full)
                        begin
                            status = mrtu_pkg::STS_NOBUF;
                        end
                        else
                        begin
                            tstart = 1'b1;
                            tload  = cfg.gap_short_us;
                        end
                    end
                    mrtu_pkg::ST_WAIT:
                    begin
                        tstart = 1'b1;
                        tload  = cfg.gap_long_us;
                        status = mrtu_pkg::STS_BUSY;
                    end
                    default: status = mrtu_pkg::STS_BUSY;
                endcase
            end
            mrtu_pkg::CMD_EXPIRY:
            begin
                unique case (st_reg)
                    mrtu_pkg::ST_INIT, mrtu_pkg::ST_EMIT, mrtu_pkg::ST_WAIT_TX:
                        status = mrtu_pkg::STS_OK;
                    mrtu_pkg::ST_RECEIVE:
                    begin
                        tstart = 1'b1;
                        tload  = gap_diff;
                    end
                    mrtu_pkg::ST_WAIT:       rdy    = addr_hit;
                    mrtu_pkg::ST_TX_TIMEOUT: status = mrtu_pkg::STS_BUSY;
                    default:                 status = mrtu_pkg::STS_FAULT;
                endcase
            end
            mrtu_pkg::CMD_RELEASE:
            begin
                unique case (st_reg)
                    mrtu_pkg::ST_PROCESS:
                    begin
                        if (cnt16 >= item.caller_capacity)
                        begin
                            status = mrtu_pkg::STS_INVALID;
                        end
                        else
                        begin
                            flen = cnt_reg;
                        end
                    end
                    mrtu_pkg::ST_EMIT, mrtu_pkg::ST_WAIT_TX, mrtu_pkg::ST_TX_TIMEOUT:
                        status = mrtu_pkg::STS_BUSY;
                    default: status = mrtu_pkg::STS_OK;
                endcase
            end
            mrtu_pkg::CMD_WRITE:
            begin
                if (tx_oversize)
                begin
                    status = mrtu_pkg::STS_INVALID;
                end
                else
                begin
                    unique case (st_reg)
                        mrtu_pkg::ST_INIT:
                        begin
                            tstart = 1'b1;
                            tload  = cfg.gap_long_us;
                            status = mrtu_pkg::STS_AGAIN;
                        end
                        mrtu_pkg::ST_IDLE:
                        begin
                            priority if (item.tx_length == 16'd0)
                            begin
                                status = mrtu_pkg::STS_FAULT;
                            end
                            else if (item.tx_error)
                            begin
                                status = mrtu_pkg::STS_WRERR;
                            end
                            else if (item.tx_taken < item.tx_length)
                            begin
                                tstart = 1'b1;
                                tload  = cfg.gap_short_us;
                                status = mrtu_pkg::STS_AGAIN;
                            end
                            else
                            begin
                                tstart = 1'b1;
                                tload  = cfg.gap_long_us;
                            end
                        end
                        mrtu_pkg::ST_EMIT:
                        begin
                            priority if (cnt16 >= item.tx_length)
                            begin
                                status = mrtu_pkg::STS_FAULT;
                            end
                            else if (item.tx_tag != tag_reg)
                            begin
                                status = mrtu_pkg::STS_BUSY;
                            end
                            else if (item.tx_length != plen_reg)
                            begin
                                status = mrtu_pkg::STS_INVALID;
                            end
                            else if (item.tx_error)
                            begin
                                tstart = 1'b1;
                                tload  = cfg.gap_long_us;
                                status = mrtu_pkg::STS_WRERR;
                            end
                            else if (item.tx_taken < remaining)
                            begin
                                tstart = 1'b1;
                                tload  = cfg.gap_short_us;
                                status = mrtu_pkg::STS_AGAIN;
                            end
                            else if (item.tx_taken == remaining)
                            begin
                                tstart = 1'b1;
                                tload  = cfg.gap_long_us;
                            end
                            else
                            begin
                                status = mrtu_pkg::STS_FAULT;
                            end
                        end
                        mrtu_pkg::ST_TX_TIMEOUT:
                        begin
                            if (item.tx_tag == tag_reg)
                            begin
                                tstart = 1'b1;
                                tload  = cfg.gap_long_us;
                                status = mrtu_pkg::STS_TIMEDOUT;
                            end
                            else
                            begin
                                status = mrtu_pkg::STS_BUSY;
                            end
                        end
                        default: status = mrtu_pkg::STS_BUSY;
                    endcase
                end
            end
            mrtu_pkg::CMD_READ: status = mrtu_pkg::STS_OK;
            default:            status = mrtu_pkg::STS_FAULT;
        endcase
    end

    // Store read for the read command
    always_comb
    begin
        rd_en   = fire && (item.cmd == mrtu_pkg::CMD_READ);
        rd_addr = wrap_index(item.read_index);
    end

    // Advance machine state and capture the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= mrtu_pkg::ST_INIT;
            cnt_reg      <= '0;
            tag_reg      <= 8'd0;
            plen_reg     <= 16'd0;
            status_reg   <= 3'd0;
            tstart_reg   <= 1'b0;
            tload_reg    <= 16'd0;
            ready_reg    <= 1'b0;
            flen_reg     <= '0;
            resume_reg   <= '0;
            read_sel_reg <= 1'b0;
        end
        else if (fire)
        begin
            st_reg       <= st_next;
            cnt_reg      <= cnt_next;
            tag_reg      <= tag_next;
            plen_reg     <= plen_next;
            status_reg   <= status;
            tstart_reg   <= tstart;
            tload_reg    <= tload;
            ready_reg    <= rdy;
            flen_reg     <= flen;
            resume_reg   <= (st_next == mrtu_pkg::ST_EMIT) ? cnt_next : '0;
            read_sel_reg <= item.cmd == mrtu_pkg::CMD_READ;
        end
    end

    // Hold the address byte of the frame in progress
    always_ff @(posedge clk)
    begin
        if (fire && wr_en && wr_addr == '0)
        begin
            first_byte_reg <= item.rx_data;
        end
    end

    `MRTU_ASSERT_IMPLY(a_emit_below_len, clk, rst_n, st_reg == mrtu_pkg::ST_EMIT, cnt16 < plen_reg, "emit count reached frame length")
    `MRTU_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, cnt_reg <= FRAME_CNT, "byte count beyond store depth")
    `MRTU_ASSERT_IMPLY(a_load_gated, clk, rst_n, !tstart_reg, tload_reg == 16'd0, "timer load without restart")
    `MRTU_ASSERT_IMPLY(a_ready_process, clk, rst_n, ready_reg, st_reg == mrtu_pkg::ST_PROCESS, "frame ready outside process state")

endmodule

### rtl/modbus_rtu_frame_fsm.sv
// Modbus RTU framing block: one command word in, one result word out.
// An accepted word is held in the input register, then its result in the result register.
// One word per cycle unless out_ch stalls; the link state keeps up, so words run back to back.
// rst_n clears the pipeline valids, the machine (init state, zero counts) and the registers
// to their defaults; store not cleared, user must read it only after it is written, unenforced.
// Depends on mrtu_pkg, mrtu_in_if, mrtu_out_if, mrtu_store, mrtu_ctrl and the assertion macros.
`include "modbus_rtu_frame_fsm_defines.svh"
module modbus_rtu_frame_fsm #(
    parameter int FRAME_BYTES = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    mrtu_in_if.sink                              in_ch,
    mrtu_out_if.source                           out_ch,
    input  logic                                 cfg_we,
    input  logic [mrtu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mrtu_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int AW    = $clog2(FRAME_BYTES);
    localparam int CNT_W = $clog2(FRAME_BYTES + 1);

    mrtu_pkg::cfg_t     cfg_reg;
    mrtu_pkg::in_item_t item_reg;
    logic               s1_valid_reg, s1_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               fire;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data;
    logic [2:0]       status_reg;
    logic             tstart_reg;
    logic [15:0]      tload_reg;
    logic             ready_reg;
    logic [CNT_W-1:0] flen_reg;
    logic [CNT_W-1:0] resume_reg;
    logic             read_sel_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.station_address <= mrtu_pkg::STATION_RESET;
            cfg_reg.gap_short_us    <= mrtu_pkg::GAP_SHORT_RESET;
            cfg_reg.gap_long_us     <= mrtu_pkg::GAP_LONG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mrtu_pkg::REG_STATION:   cfg_reg.station_address <= cfg_wdata[7:0];
                mrtu_pkg::REG_GAP_SHORT: cfg_reg.gap_short_us    <= cfg_wdata;
                mrtu_pkg::REG_GAP_LONG:  cfg_reg.gap_long_us     <= cfg_wdata;
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Pipeline handshake: process a held word when the result slot is free
    always_comb
    begin
        fire           = s1_valid_reg && (!out_valid_reg || out_ch.ready);
        in_ch.ready    = !s1_valid_reg || fire;
        s1_valid_next  = (in_ch.valid && in_ch.ready) ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
        out_valid_next = fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.cmd             <= in_ch.cmd;
            item_reg.rx_data         <= in_ch.rx_data;
            item_reg.read_index      <= in_ch.read_index;
            item_reg.caller_capacity <= in_ch.caller_capacity;
            item_reg.tx_length       <= in_ch.tx_length;
            item_reg.tx_tag          <= in_ch.tx_tag;
            item_reg.tx_taken        <= in_ch.tx_taken;
            item_reg.tx_error        <= in_ch.tx_error;
        end
    end

    mrtu_store #(
        .DEPTH (FRAME_BYTES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mrtu_ctrl #(
        .FRAME_BYTES (FRAME_BYTES),
        .AW          (AW),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .item         (item_reg),
        .cfg          (cfg_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .status_reg   (status_reg),
        .tstart_reg   (tstart_reg),
        .tload_reg    (tload_reg),
        .ready_reg    (ready_reg),
        .flen_reg     (flen_reg),
        .resume_reg   (resume_reg),
        .read_sel_reg (read_sel_reg)
    );

    // Drive the result word
    always_comb
    begin
        out_ch.valid            = out_valid_reg;
        out_ch.status           = status_reg;
        out_ch.timer_start      = tstart_reg;
        out_ch.timer_load_us    = tload_reg;
        out_ch.frame_ready      = ready_reg;
        out_ch.frame_length     = flen_reg;
        out_ch.read_data        = read_sel_reg ? rd_data : 8'd0;
        out_ch.tx_resume_offset = resume_reg;
    end

    `MRTU_ASSERT_NEXT(a_accept_held, clk, rst_n, in_ch.valid && in_ch.ready, s1_valid_reg,
        "accepted word not held")
    `MRTU_ASSERT_NEXT(a_fire_result, clk, rst_n, fire, out_valid_reg,
        "processed word gave no result")
    `MRTU_ASSERT_IMPLY(a_no_overwrite, clk, rst_n, fire, !out_valid_reg || out_ch.ready,
        "result overwritten while stalled")

endmodule

### dv/modbus_rtu_frame_fsm_tb.sv
// Self-checking testbench for the Modbus RTU framing block: a directed table, then random
// word sequences shaped by the link state, checked against an in-bench predictor.
// Depends on mrtu_pkg, mrtu_in_if, mrtu_out_if and modbus_rtu_frame_fsm.
module modbus_rtu_frame_fsm_tb;
    import mrtu_pkg::*;

    localparam int STORE_DEPTH     = 256;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int QUIET_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASES          = 5;
    localparam int REPORT_LIMIT    = 10;
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // One result word as the block returns it
    typedef struct packed {
        status_t     status;
        logic        timer_start;
        logic [15:0] timer_load_us;
        logic        frame_ready;
        logic [8:0]  frame_length;
        logic [7:0]  read_data;
        logic [8:0]  tx_resume_offset;
    } reply_t;

    // One row of the directed table
    typedef struct {
        in_item_t word;
        bit       fixed;
        reply_t   reply;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    mrtu_in_if             in_ch ();
    mrtu_out_if #(.CNT_W(9)) out_ch ();

    modbus_rtu_frame_fsm #(
        .FRAME_BYTES (STORE_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Link state mirror
    link_state_t lk_state;
    logic [8:0]  lk_count;
    logic [7:0]  lk_tag;
    logic [15:0] lk_len;
    logic [7:0]  lk_store [STORE_DEPTH];
    int          stored_upto;
    cfg_t        lk_cfg;

    reply_t      awaited_replies [$];
    plan_row_t   plan [$];
    int          fail_count;
    int          quiet_cycles;

    // Word in flight from the sender, with an optional hand-written reply
    bit          offer_fixed;
    reply_t      offer_reply;

    // Stimulus shaping
    int          frame_target;
    int          frame_bytes_sent;
    bit          force_long;
    bit          hold_off_request;
    int          src_calm_left;
    int          sink_calm_left;
    int          sink_stall_left;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Work out the reply to one word and advance the link mirror
    function automatic reply_t frame_link_step(in_item_t w);
        reply_t r;
        int     len;
        int     taken;
        int     rem;
        r = '0;
        r.status = STS_OK;
        len = w.tx_length;
        taken = w.tx_taken;
        case (w.cmd)
            CMD_RX:
            begin
                case (lk_state)
                    ST_INIT:
                    begin
                        {r.timer_start, r.timer_load_us} = {1'b1, lk_cfg.gap_long_us};
                        r.status = STS_AGAIN;
                    end
                    ST_IDLE:
                    begin
                        lk_store[0] = w.rx_data;
                        if (stored_upto < 1)
                            stored_upto = 1;
                        lk_count = 9'd1;
                        {r.timer_start, r.timer_load_us} = {1'b1, lk_cfg.gap_short_us};
                        lk_state = ST_RECEIVE;
                    end
                    ST_RECEIVE:
                    begin
                        if (lk_count >= STORE_DEPTH)
                            r.status = STS_NOBUF;
                        else
                        begin
                            lk_store[lk_count] = w.rx_data;
                            lk_count = lk_count + 9'd1;
                            if (stored_upto < int'(lk_count))
                                stored_upto = lk_count;
                            {r.timer_start, r.timer_load_us} = {1'b1, lk_cfg.gap_short_us};
                        end
                    end
                    ST_WAIT:
                    begin
                        {r.timer_start, r.timer_load_us} = {1'b1, lk_cfg.gap_long_us};
                        r.status = STS_BUSY;
                    end
                    default: r.status = STS_BUSY;
                endcase
            end
            CMD_EXPIRY:
            begin
                case (lk_state)
                    ST_INIT:
                    begin
                        lk_state = ST_IDLE;
                        lk_count = '0;
                    end
                    ST_EMIT:    lk_state = ST_TX_TIMEOUT;
                    ST_RECEIVE:
                    begin
                        lk_state = ST_WAIT;
                        r.timer_start = 1'b1;
                        r.timer_load_us = (lk_cfg.gap_long_us >= lk_cfg.gap_short_us) ?
                            lk_cfg.gap_long_us - lk_cfg.gap_short_us : 16'd0;
                    end
                    ST_WAIT:
                    begin
                        // Keep frames for our station or broadcast, drop the rest
                        if (lk_store[0] == 8'h00 || lk_store[0] == lk_cfg.station_address)
                        begin
                            lk_state = ST_PROCESS;
                            r.frame_ready = 1'b1;
                        end
                        else
                            lk_state = ST_IDLE;
                    end
                    ST_WAIT_TX:    lk_state = ST_IDLE;
                    ST_TX_TIMEOUT: r.status = STS_BUSY;
                    default:       r.status = STS_FAULT;
                endcase
            end
            CMD_RELEASE:
            begin
                case (lk_state)
                    ST_PROCESS:
                    begin
                        if (lk_count >= w.caller_capacity)
                            r.status = STS_INVALID;
                        else
                        begin
                            r.frame_length = lk_count;
                            lk_state = ST_IDLE;
                        end
                    end
                    ST_EMIT, ST_WAIT_TX, ST_TX_TIMEOUT: r.status = STS_BUSY;
                    default: ;
                endcase
            end
            CMD_WRITE:
            begin
                if (len > STORE_DEPTH)
                    r.status = STS_INVALID;
                else
                begin
                    case (lk_state)
                        ST_INIT:
                        begin
                            {r.timer_start, r.timer_load_us} = {1'b1, lk_cfg.gap_long_us};
                            r.status = STS_AGAIN;
                        end
                        ST_IDLE:
                        begin
                            if (len == 0)
                                r.status = STS_FAULT;
                            else if (w.tx_error)
                                r.status = STS_WRERR;
                            else if (taken < len)
                            begin
                                lk_count = 9'(taken);
                                lk_state = ST_EMIT;
                                lk_tag = w.tx_tag;
                                lk_len = w.tx_length;
                                {r.timer_start, r.timer_load_us} =
                                    {1'b1, lk_cfg.gap_short_us};
                                r.status = STS_AGAIN;
                            end
                            else
                            begin
                                lk_state = ST_WAIT_TX;
                                {r.timer_start, r.timer_load_us} = {1'b1, lk_cfg.gap_long_us};
                                r.status = STS_OK;
                            end
                        end
                        ST_EMIT:
                        begin
                            rem = len - int'(lk_count);
                            if (int'(lk_count) >= len)
                                r.status = STS_FAULT;
                            else if (w.tx_tag != lk_tag)
                                r.status = STS_BUSY;
                            else if (w.tx_length != lk_len)
                                r.status = STS_INVALID;
                            else if (w.tx_error)
                            begin
                                lk_state = ST_WAIT_TX;
                                {r.timer_start, r.timer_load_us} = {1'b1, lk_cfg.gap_long_us};
                                r.status = STS_WRERR;
                            end
                            else if (taken < rem)
                            begin
                                lk_count = lk_count + 9'(taken);
                                {r.timer_start, r.timer_load_us} =
                                    {1'b1, lk_cfg.gap_short_us};
                                r.status = STS_AGAIN;
                            end
                            else if (taken == rem)
                            begin
                                lk_state = ST_WAIT_TX;
                                {r.timer_start, r.timer_load_us} = {1'b1, lk_cfg.gap_long_us};
                                r.status = STS_OK;
                            end
                            else
                                r.status = STS_FAULT;
                        end
                        ST_TX_TIMEOUT:
                        begin
                            if (w.tx_tag == lk_tag)
                            begin
                                lk_state = ST_WAIT_TX;
                                {r.timer_start, r.timer_load_us} = {1'b1, lk_cfg.gap_long_us};
                                r.status = STS_TIMEDOUT;
                            end
                            else
                                r.status = STS_BUSY;
                        end
                        default: r.status = STS_BUSY;
                    endcase
                end
            end
            CMD_READ: r.read_data = lk_store[w.read_index];
            default:  r.status = STS_FAULT;
        endcase
        r.tx_resume_offset = (lk_state == ST_EMIT) ? lk_count : 9'd0;
        return r;
    endfunction

    // Record a failure; detail only for the first few
    function automatic void flag_reply(string what, reply_t want, reply_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t %s: expected st=%0d ts=%0b ld=%0d fr=%0b len=%0d rd=%0d off=%0d",
                     $realtime, what, want.status, want.timer_start, want.timer_load_us,
                     want.frame_ready, want.frame_length, want.read_data,
                     want.tx_resume_offset);
        if (fail_count <= REPORT_LIMIT)
            $display("    actual st=%0d ts=%0b ld=%0d fr=%0b len=%0d rd=%0d off=%0d",
                     got.status, got.timer_start, got.timer_load_us, got.frame_ready,
                     got.frame_length, got.read_data, got.tx_resume_offset);
    endfunction

    // Predict on every accepted word, compare every accepted reply
    always @(posedge clk)
    begin
        in_item_t w;
        reply_t   want;
        reply_t   got;
        bit       moved;
        if (rst_n === 1'b1)
        begin
            moved = 1'b0;
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            begin
                w = {in_ch.cmd, in_ch.rx_data, in_ch.read_index, in_ch.caller_capacity,
                     in_ch.tx_length, in_ch.tx_tag, in_ch.tx_taken, in_ch.tx_error};
                want = frame_link_step(w);
                if (offer_fixed)
                    want = offer_reply;
                awaited_replies.push_back(want);
                moved = 1'b1;
            end
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got = {out_ch.status, out_ch.timer_start, out_ch.timer_load_us,
                       out_ch.frame_ready, out_ch.frame_length, out_ch.read_data,
                       out_ch.tx_resume_offset};
                if (awaited_replies.size() == 0)
                    flag_reply("reply with nothing awaited", '0, got);
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got.status !== want.status ||
                        got.timer_start !== want.timer_start ||
                        got.timer_load_us !== want.timer_load_us ||
                        got.frame_ready !== want.frame_ready ||
                        got.frame_length !== want.frame_length ||
                        got.read_data !== want.read_data ||
                        got.tx_resume_offset !== want.tx_resume_offset)
                        flag_reply("reply mismatch", want, got);
                end
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // End the run if the channels go quiet for too long
    initial
    begin
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("modbus_rtu_frame_fsm verification failed");
        $finish;
    end

    // Result side: random stalls, calm stretches and one long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        sink_calm_left = 0;
        sink_stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            int r;
            @(negedge clk);
            r = $urandom_range(0, 99);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                sink_stall_left = HOLD_OFF_CYCLES;
                sink_calm_left = 0;
            end
            else if (sink_stall_left > 0)
                sink_stall_left--;
            else if (sink_calm_left > 0)
                sink_calm_left--;
            else if (r < 4)
                sink_calm_left = $urandom_range(20, 80);
            else if (r >= 70 && r < 94)
                sink_stall_left = $urandom_range(1, 3);
            else if (r >= 94)
                sink_stall_left = $urandom_range(10, 40);
            out_ch.ready <= (sink_stall_left == 0);
        end
    end

    // Gap before the next word: mostly none or short, a few long
    function automatic int source_pause();
        int r;
        r = $urandom_range(0, 99);
        if (src_calm_left > 0)
        begin
            src_calm_left--;
            return 0;
        end
        if (r < 5)
        begin
            src_calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_stored_index();
        if ($urandom_range(0, 3) == 0)
            return 8'(stored_upto - 1);
        return 8'($urandom_range(0, stored_upto - 1));
    endfunction

    // Fully random word; reads stay within the written part of the store
    function automatic in_item_t noise_word();
        in_item_t w;
        w = {3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 16'($urandom),
             16'($urandom), 8'($urandom), 16'($urandom), 1'($urandom)};
        if (w.cmd == CMD_READ)
        begin
            if (stored_upto == 0)
                w.cmd = CMD_EXPIRY;
            else
                w.read_index = pick_stored_index();
        end
        return w;
    endfunction

    // Next word, steered by the link state towards well-formed exchanges
    function automatic in_item_t next_word();
        in_item_t w;
        int       r;
        int       rem;
        w = noise_word();
        r = $urandom_range(0, 99);
        if (r < 12 && !(lk_state == ST_RECEIVE && frame_target > 200))
            return w;
        r = $urandom_range(0, 99);
        case (lk_state)
            ST_INIT: w.cmd = (r < 25) ? CMD_RX : CMD_EXPIRY;
            ST_IDLE:
            begin
                if (r < 55)
                begin
                    // Open a new frame with a chosen address and length
                    w.cmd = CMD_RX;
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        w.rx_data = lk_cfg.station_address;
                    else if (r < 60)
                        w.rx_data = 8'h00;
                    frame_bytes_sent = 1;
                    if (force_long)
                    begin
                        frame_target = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
                        force_long = 1'b0;
                    end
                    else if ($urandom_range(0, 24) == 0)
                        frame_target = $urandom_range(20, 60);
                    else
                        frame_target = $urandom_range(1, 8);
                end
                else if (r < 85)
                begin
                    w.cmd = CMD_WRITE;
                    r = $urandom_range(0, 19);
                    w.tx_length = (r == 0) ? 16'(STORE_DEPTH) :
                                  (r == 1) ? 16'd0 : 16'($urandom_range(1, 12));
                    w.tx_error = ($urandom_range(0, 9) == 0);
                    if (w.tx_length != 0)
                        w.tx_taken = ($urandom_range(0, 3) == 0) ?
                            16'($urandom_range(w.tx_length, 65535)) :
                            16'($urandom_range(0, w.tx_length - 1));
                end
                else if (stored_upto > 0)
                begin
                    w.cmd = CMD_READ;
                    w.read_index = pick_stored_index();
                end
                else
                    w.cmd = CMD_RELEASE;
            end
            ST_RECEIVE:
            begin
                if (frame_bytes_sent < frame_target)
                begin
                    w.cmd = CMD_RX;
                    frame_bytes_sent++;
                end
                else
                    w.cmd = CMD_EXPIRY;
            end
            ST_WAIT: w.cmd = (r < 80) ? CMD_EXPIRY : CMD_RX;
            ST_PROCESS:
            begin
                if (r < 40)
                begin
                    w.cmd = CMD_READ;
                    w.read_index = pick_stored_index();
                end
                else if (r < 85)
                begin
                    w.cmd = CMD_RELEASE;
                    w.caller_capacity = ($urandom_range(0, 9) < 7) ?
                        16'($urandom_range(int'(lk_count) + 1, 65535)) :
                        16'($urandom_range(0, lk_count));
                end
                else
                    w.cmd = (r < 93) ? CMD_EXPIRY : CMD_RX;
            end
            ST_EMIT:
            begin
                rem = int'(lk_len) - int'(lk_count);
                w.tx_tag = lk_tag;
                w.tx_length = lk_len;
                if (r < 75)
                begin
                    // Continue the transfer: partial, exact or overreaching
                    w.cmd = CMD_WRITE;
                    w.tx_error = ($urandom_range(0, 11) == 0);
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        w.tx_taken = 16'($urandom_range(0, rem - 1));
                    else if (r < 85)
                        w.tx_taken = 16'(rem);
                    else
                        w.tx_taken = 16'($urandom_range(rem + 1, 65535));
                end
                else if (r < 85)
                begin
                    w.cmd = CMD_WRITE;
                    if (r < 80)
                        w.tx_tag = lk_tag ^ 8'($urandom_range(1, 255));
                    else
                        w.tx_length = (lk_len % 16'(STORE_DEPTH)) + 16'd1;
                end
                else
                    w.cmd = (r < 95) ? CMD_EXPIRY : CMD_RELEASE;
            end
            ST_TX_TIMEOUT:
            begin
                w.tx_length = 16'($urandom_range(0, STORE_DEPTH));
                if (r < 85)
                begin
                    w.cmd = CMD_WRITE;
                    w.tx_tag = (r < 70) ? lk_tag : lk_tag ^ 8'($urandom_range(1, 255));
                end
                else
                    w.cmd = CMD_EXPIRY;
            end
            ST_WAIT_TX:
            begin
                if (r < 85)
                    w.cmd = CMD_EXPIRY;
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic void plan_add(logic [2:0] cmd, logic [7:0] data, logic [7:0] idx,
                                     logic [15:0] cap, logic [15:0] len, logic [7:0] tag,
                                     logic [15:0] taken, logic err, bit fixed = 1'b0,
                                     status_t sts = STS_OK, logic ts = 1'b0,
                                     logic [15:0] load = '0);
        plan_row_t row;
        row.word = {cmd, data, idx, cap, len, tag, taken, err};
        row.fixed = fixed;
        row.reply = '0;
        row.reply.status = sts;
        row.reply.timer_start = ts;
        row.reply.timer_load_us = load;
        plan.push_back(row);
    endfunction

    // Offer one word and hold it until accepted
    task automatic offer_word(in_item_t w);
        in_ch.valid <= 1'b1;
        {in_ch.cmd, in_ch.rx_data, in_ch.read_index, in_ch.caller_capacity,
         in_ch.tx_length, in_ch.tx_tag, in_ch.tx_taken, in_ch.tx_error} <= w;
        do
            @(posedge clk);
        while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
        @(negedge clk);
    endtask

    task automatic source_gap(int n);
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Stop offering until every awaited reply has arrived
    task automatic drain_replies();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_replies.size() != 0);
    endtask

    task automatic apply_settings(logic [7:0] station, logic [15:0] short_us,
                                  logic [15:0] long_us);
        cfg_we <= 1'b1;
        cfg_index <= REG_STATION;
        cfg_wdata <= {8'h00, station};
        @(negedge clk);
        cfg_index <= REG_GAP_SHORT;
        cfg_wdata <= short_us;
        @(negedge clk);
        cfg_index <= REG_GAP_LONG;
        cfg_wdata <= long_us;
        @(negedge clk);
        cfg_we <= 1'b0;
        lk_cfg = {station, short_us, long_us};
    endtask

    // Stimulus
    initial
    begin
        logic [15:0] same_gap;
        int          words;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_STATION;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        {in_ch.cmd, in_ch.rx_data, in_ch.read_index, in_ch.caller_capacity,
         in_ch.tx_length, in_ch.tx_tag, in_ch.tx_taken, in_ch.tx_error} = '0;
        lk_state = ST_INIT;
        lk_count = '0;
        lk_tag = '0;
        lk_len = '0;
        stored_upto = 0;
        lk_cfg = {STATION_RESET, GAP_SHORT_RESET, GAP_LONG_RESET};
        fail_count = 0;
        offer_fixed = 1'b0;
        offer_reply = '0;
        frame_target = 1;
        frame_bytes_sent = 0;
        force_long = 1'b0;
        hold_off_request = 1'b0;
        src_calm_left = 0;

        // Directed table: init refusals, a broadcast frame, a full transmit cycle
        plan_add(CMD_RX, 8'hFF, 0, 0, 0, 0, 0, 0, 1, STS_AGAIN, 1, GAP_LONG_RESET);
        plan_add(CMD_WRITE, 0, 0, 0, 16'hFFFF, 8'hFF, 16'hFFFF, 1, 1, STS_INVALID);
        plan_add(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0, 1, STS_FAULT);
        plan_add(CMD_EXPIRY, 0, 0, 0, 0, 0, 0, 0, 1, STS_OK);
        plan_add(CMD_EXPIRY, 0, 0, 0, 0, 0, 0, 0, 1, STS_FAULT);
        plan_add(CMD_WRITE, 0, 0, 0, 0, 8'h12, 0, 0, 1, STS_FAULT);
        plan_add(CMD_WRITE, 0, 0, 0, 16'd256, 0, 0, 1, 1, STS_WRERR);
        plan_add(CMD_RELEASE, 0, 0, 0, 0, 0, 0, 0, 1, STS_OK);
        plan_add(CMD_RX, 8'h00, 0, 0, 0, 0, 0, 0);
        plan_add(CMD_RX, 8'hFF, 0, 0, 0, 0, 0, 0);
        plan_add(CMD_EXPIRY, 0, 0, 0, 0, 0, 0, 0);
        plan_add(CMD_RX, 8'hA5, 0, 0, 0, 0, 0, 0);
        plan_add(CMD_EXPIRY, 0, 0, 0, 0, 0, 0, 0);
        plan_add(CMD_EXPIRY, 0, 0, 0, 0, 0, 0, 0);
        plan_add(CMD_READ, 0, 8'd0, 0, 0, 0, 0, 0);
        plan_add(CMD_READ, 0, 8'd1, 0, 0, 0, 0, 0);
        plan_add(CMD_RELEASE, 0, 0, 16'd2, 0, 0, 0, 0);
        plan_add(CMD_RELEASE, 0, 0, 16'hFFFF, 0, 0, 0, 0);
        plan_add(CMD_WRITE, 0, 0, 0, 16'd10, 8'hFF, 16'd3, 0);
        plan_add(CMD_RELEASE, 0, 0, 16'hFFFF, 0, 0, 0, 0);
        plan_add(CMD_WRITE, 0, 0, 0, 16'd10, 8'h00, 16'd1, 0);
        plan_add(CMD_WRITE, 0, 0, 0, 16'd11, 8'hFF, 16'd1, 0);
        plan_add(CMD_WRITE, 0, 0, 0, 16'd10, 8'hFF, 16'd8, 0);
        plan_add(CMD_EXPIRY, 0, 0, 0, 0, 0, 0, 0);
        plan_add(CMD_EXPIRY, 0, 0, 0, 0, 0, 0, 0);
        plan_add(CMD_WRITE, 0, 0, 0, 16'd10, 8'hFF, 16'd0, 0);
        plan_add(CMD_EXPIRY, 0, 0, 0, 0, 0, 0, 0);
        plan_add(CMD_WRITE, 0, 0, 0, 16'd1, 8'h00, 16'hFFFF, 0);
        plan_add(CMD_EXPIRY, 0, 0, 0, 0, 0, 0, 0);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (plan[i])
        begin
            source_gap(source_pause());
            offer_fixed = plan[i].fixed;
            offer_reply = plan[i].reply;
            offer_word(plan[i].word);
        end
        offer_fixed = 1'b0;

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_replies();
            repeat (SETTLE_CYCLES) @(negedge clk);
            words = 80;
            case (ph)
                0: apply_settings(8'h7E, 16'd600, 16'd1400);
                1:
                begin
                    // Extreme gaps, top station address and one oversize frame
                    apply_settings(8'd254, 16'd0, 16'hFFFF);
                    force_long = 1'b1;
                    words = 360;
                end
                2: apply_settings(8'd1, 16'hFFFF, 16'd0);
                3: apply_settings(8'($urandom_range(1, 254)), 16'($urandom), 16'($urandom));
                default:
                begin
                    same_gap = 16'($urandom);
                    apply_settings(8'($urandom_range(1, 254)), same_gap, same_gap);
                end
            endcase
            for (int k = 0; k < words; k++)
            begin
                if (ph == 1 && k == 20)
                    hold_off_request = 1'b1;
                if (ph == 2 && k == 50)
                    drain_replies();
                source_gap(source_pause());
                offer_word(next_word());
            end
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && awaited_replies.size() == 0)
            $display("modbus_rtu_frame_fsm verification clean");
        else
            $display("modbus_rtu_frame_fsm verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/mrtu_pkg.sv
rtl/mrtu_in_if.sv
rtl/mrtu_out_if.sv
rtl/mrtu_store.sv
rtl/mrtu_ctrl.sv
rtl/modbus_rtu_frame_fsm.sv
dv/modbus_rtu_frame_fsm_tb.sv
